// ===== hdl/mi3_pkg.sv =====
// mi3_pkg: payload types, cofactor index table and the saturation helper
// for the 3x3 matrix inverse. No dependencies.
package mi3_pkg;

  typedef struct packed {
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] m3;
    logic signed [31:0] m4;
    logic signed [31:0] m5;
    logic signed [31:0] m6;
    logic signed [31:0] m7;
    logic signed [31:0] m8;
  } mat_in_t;

  typedef struct packed {
    logic signed [31:0] r0;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] r3;
    logic signed [31:0] r4;
    logic signed [31:0] r5;
    logic signed [31:0] r6;
    logic signed [31:0] r7;
    logic signed [31:0] r8;
    logic               singular;
  } mat_out_t;

  // front end status handed to the divider lanes
  typedef struct packed {
    logic        valid;
    logic        det_zero;
    logic        det_neg;
    logic [96:0] det_abs;
  } front_t;

  // cofactor k = m[a]*m[b] - m[c]*m[d]
  localparam logic [3:0] COF_IDX [0:8][0:3] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAG = 32'h8000_0000;

  function automatic logic [31:0] saturate(input logic [31:0] q, input logic big,
                                           input logic neg);
    logic [31:0] mag;
    if (neg) begin
      mag = (big || (q > NEG_MAG)) ? NEG_MAG : q;
      saturate = 32'd0 - mag;
    end else begin
      saturate = (big || q[31]) ? POS_MAX : q;
    end
  endfunction

endpackage

// ===== hdl/mi3_front.sv =====
// mi3_front: products, cofactors, determinant and magnitudes, five stages.
// Depends on mi3_pkg.
module mi3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mi3_pkg::mat_in_t  matrix,
  output mi3_pkg::front_t   status,
  output mi3_pkg::mat_in_t  matrix_d,
  output logic [63:0]       cof_mag [0:8],
  output logic [8:0]        cof_neg
);

  logic [4:0]              valid;
  mi3_pkg::mat_in_t        mat [0:4];
  logic signed [31:0]      mv [0:8];
  logic signed [31:0]      mv3 [0:2];
  logic signed [63:0]      pa [0:8];
  logic signed [63:0]      pb [0:8];
  logic signed [64:0]      cof2 [0:8];
  logic signed [64:0]      cof3 [0:8];
  logic signed [64:0]      cof4 [0:8];
  logic signed [64:0]      php [0:2];
  logic signed [64:0]      plp [0:2];
  logic signed [97:0]      det;
  logic signed [97:0]      det_next;
  logic                    det_zero;
  logic                    det_neg;
  logic [96:0]             det_abs;

  assign mv[0] = matrix.m0;
  assign mv[1] = matrix.m1;
  assign mv[2] = matrix.m2;
  assign mv[3] = matrix.m3;
  assign mv[4] = matrix.m4;
  assign mv[5] = matrix.m5;
  assign mv[6] = matrix.m6;
  assign mv[7] = matrix.m7;
  assign mv[8] = matrix.m8;

  // first column of the delayed matrix drives the expansion
  assign mv3[0] = mat[1].m0;
  assign mv3[1] = mat[1].m3;
  assign mv3[2] = mat[1].m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    mat[0] <= matrix;
    for (int s = 1; s < 5; s++) mat[s] <= mat[s-1];
  end

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clk) begin
        pa[k]   <= 64'(mv[mi3_pkg::COF_IDX[k][0]]) * 64'(mv[mi3_pkg::COF_IDX[k][1]]);
        pb[k]   <= 64'(mv[mi3_pkg::COF_IDX[k][2]]) * 64'(mv[mi3_pkg::COF_IDX[k][3]]);
        cof2[k] <= 65'(pa[k]) - 65'(pb[k]);
        cof3[k] <= cof2[k];
        cof4[k] <= cof3[k];
        cof_neg[k] <= cof4[k][64];
        cof_mag[k] <= cof4[k][64] ? 64'(-cof4[k]) : cof4[k][63:0];
      end
    end
  endgenerate

  // cofactor split into a signed high half and unsigned low half
  genvar j;
  generate
    for (j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clk) begin
        php[j] <= 65'($signed(cof2[j][64:32])) * 65'(mv3[j]);
        plp[j] <= 65'($signed({1'b0, cof2[j][31:0]})) * 65'(mv3[j]);
      end
    end
  endgenerate

  always_comb begin
    det_next = '0;
    for (int i = 0; i < 3; i++) begin
      det_next = det_next + (98'(php[i]) <<< 32) + 98'(plp[i]);
    end
  end

  always_ff @(posedge clk) begin
    det      <= det_next;
    det_zero <= (det == '0);
    det_neg  <= det[97];
    det_abs  <= det[97] ? 97'(-det) : det[96:0];
  end

  assign status.valid    = valid[4];
  assign status.det_zero = det_zero;
  assign status.det_neg  = det_neg;
  assign status.det_abs  = det_abs;
  assign matrix_d        = mat[4];

endmodule

// ===== hdl/mi3_lane.sv =====
// mi3_lane: pipelined restoring divider for one adjugate entry, an input
// stage, then one quotient bit per stage, 33 stages. Depends on nothing.
module mi3_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic [63:0] mag,
  input  logic        neg,
  input  logic [96:0] det_abs,
  output logic [31:0] quot,
  output logic        big,
  output logic        neg_out
);

  localparam int CW = 130;

  logic [CW-1:0] num;
  logic [CW-1:0] rem [0:31];
  logic [96:0]   dv  [0:31];
  logic [31:0]   qs  [0:32];
  logic          bg  [0:32];
  logic          ng  [0:32];

  assign num = CW'(mag) << (2 * FRAC_BITS);

  // quotient of 2^32 or more saturates, so only the low 32 bits are formed
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= det_abs;
    qs[0]  <= '0;
    bg[0]  <= num >= (CW'(det_abs) << 32);
    ng[0]  <= neg;
  end

  genvar s;
  generate
    for (s = 1; s <= 32; s++) begin : g_stage
      logic [CW-1:0] sub;
      logic          ge;
      assign sub = CW'(dv[s-1]) << (32 - s);
      assign ge  = rem[s-1] >= sub;
      always_ff @(posedge clk) begin
        qs[s] <= qs[s-1] | (32'(ge) << (32 - s));
        bg[s] <= bg[s-1];
        ng[s] <= ng[s-1];
      end
      if (s < 32) begin : g_rem
        always_ff @(posedge clk) begin
          rem[s] <= ge ? rem[s-1] - sub : rem[s-1];
          dv[s]  <= dv[s-1];
        end
      end
    end
  endgenerate

  assign quot    = qs[32];
  assign big     = bg[32];
  assign neg_out = ng[32];

endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// matrix3x3_inverse: top level, front end, nine divider lanes and the
// merge stage. Depends on mi3_pkg, mi3_front and mi3_lane.
//
// Usage: drive matrix and raise start for one cycle per beat; busy is
// always low, so a new matrix may be presented every cycle.
// Each beat comes back on result with done high for exactly one cycle,
// after 5 front end stages (products, cofactors, determinant partials,
// determinant, magnitudes), 33 divider stages in each of the nine lanes
// (an input stage, then one quotient bit per stage) and one merge stage.
// Throughput is one matrix per cycle; results leave in input order.
// A zero determinant returns the input entries with singular set.
// Out of range quotients saturate to the Q format limits.
// Reset clears the valid pipeline; beats in flight are dropped.
// The receiver cannot stall: a result must be taken in its done cycle.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mi3_pkg::mat_in_t  matrix,
  output logic              done,
  output mi3_pkg::mat_out_t result
);

  localparam int LAT = 33;

  mi3_pkg::front_t   fst;
  mi3_pkg::mat_in_t  fmat;
  logic [63:0]       cof_mag [0:8];
  logic [8:0]        cof_neg;
  logic [31:0]       quot [0:8];
  logic [8:0]        big;
  logic [8:0]        qneg;
  logic [LAT-1:0]    vld;
  logic              sng [0:LAT-1];
  mi3_pkg::mat_in_t  mdl [0:LAT-1];
  logic [31:0]       rv  [0:8];
  logic              rsng;
  logic [31:0]       mo  [0:8];

  assign busy = 1'b0;

  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .matrix   (matrix),
    .status   (fst),
    .matrix_d (fmat),
    .cof_mag  (cof_mag),
    .cof_neg  (cof_neg)
  );

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_lane
      mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk     (clk),
        .mag     (cof_mag[k]),
        .neg     (cof_neg[k] ^ fst.det_neg),
        .det_abs (fst.det_abs),
        .quot    (quot[k]),
        .big     (big[k]),
        .neg_out (qneg[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-2:0], fst.valid};
      done <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    sng[0] <= fst.det_zero;
    mdl[0] <= fmat;
    for (int s = 1; s < LAT; s++) begin
      sng[s] <= sng[s-1];
      mdl[s] <= mdl[s-1];
    end
  end

  assign mo[0] = mdl[LAT-1].m0;
  assign mo[1] = mdl[LAT-1].m1;
  assign mo[2] = mdl[LAT-1].m2;
  assign mo[3] = mdl[LAT-1].m3;
  assign mo[4] = mdl[LAT-1].m4;
  assign mo[5] = mdl[LAT-1].m5;
  assign mo[6] = mdl[LAT-1].m6;
  assign mo[7] = mdl[LAT-1].m7;
  assign mo[8] = mdl[LAT-1].m8;

  // merge: singular beats echo the input matrix
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      rv[i] <= sng[LAT-1] ? mo[i] : mi3_pkg::saturate(quot[i], big[i], qneg[i]);
    end
    rsng <= sng[LAT-1];
  end

  assign result.r0       = rv[0];
  assign result.r1       = rv[1];
  assign result.r2       = rv[2];
  assign result.r3       = rv[3];
  assign result.r4       = rv[4];
  assign result.r5       = rv[5];
  assign result.r6       = rv[6];
  assign result.r7       = rv[7];
  assign result.r8       = rv[8];
  assign result.singular = rsng;

endmodule
